// ===== src/ddmcw_pkg.sv =====
// ----------------------------------------------------------------------------
// ddmcw_pkg
// Register indexes and saturating helpers for the confidence walk unit.
// ----------------------------------------------------------------------------
package ddmcw_pkg;

    typedef enum logic [2:0] {
        REG_BOUND_UPPER       = 3'd0,
        REG_START_EVIDENCE    = 3'd1,
        REG_DRIFT_STEP        = 3'd2,
        REG_POST_DRIFT_STEP   = 3'd3,
        REG_NOISE_GAIN        = 3'd4,
        REG_CONFIDENCE_WIDTH  = 3'd5,
        REG_URGENCY_STEP      = 3'd6,
        REG_NONDECISION_STEPS = 3'd7
    } cfg_index_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 32;
    localparam int unsigned NOISE_W     = 36;   // scaled noise, Q20.16 signed
    localparam int unsigned SUM_W       = 38;   // evidence + drift + noise

    localparam logic [30:0] RESET_BOUND_UPPER    = 31'd65536;
    localparam logic [30:0] RESET_START_EVIDENCE = 31'd32768;
    localparam logic [30:0] RESET_NOISE_GAIN     = 31'd655;
    localparam logic [30:0] RESET_CONF_WIDTH     = 31'd65536;

    // clamp a wide signed value to 32-bit signed
    function automatic logic [31:0] sat32(input logic [SUM_W-1:0] v);
        logic [31:0] r;
        if ((v[SUM_W-1:31] == '0) || (v[SUM_W-1:31] == '1))
        begin
            r = v[31:0];
        end
        else if (v[SUM_W-1])
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat_add_u32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage

// ===== src/ddm_confidence_walk_unit.sv =====
// ----------------------------------------------------------------------------
// ddm_confidence_walk_unit
// Drift diffusion walk with collapsing confidence bounds, one step per sample.
// ----------------------------------------------------------------------------
// usage
//   sample channel: noise_sample with sample_valid / sample_stall; one request
//   is one walk step. result channel: one request per finished trial with
//   result_valid / result_stall. configuration: cfg_write with cfg_index and
//   cfg_data, written by the user only while the unit is idle (no sample in
//   flight), which the unit does not enforce. a sample passes a multiply
//   stage (gain times sample, rounded) and then the walk update stage, which
//   writes the result register and raises result_valid when a trial ends.
//   throughput is one sample per cycle while results are not stalled, set by
//   the walk update (one wide add, saturation and the bound compares) feeding
//   back on itself. when the receiver stalls, the finished result holds in
//   its register and one more sample may still enter the multiply stage;
//   sample_stall rises only once that stage holds a sample that cannot move
//   on. reset restores the register defaults, empties both stages and starts
//   trial zero at the start evidence.
// ----------------------------------------------------------------------------
module ddm_confidence_walk_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ddmcw_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [ddmcw_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                  sample_valid,
    output logic                                  sample_stall,
    input  logic signed [15:0]                    noise_sample,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output logic [31:0]                           trial_index,
    output logic [31:0]                           decision_rt,
    output logic                                  response_upper,
    output logic                                  correct,
    output logic signed [31:0]                    final_evidence,
    output logic [31:0]                           full_rt,
    output logic [31:0]                           confidence_rt,
    output logic signed [31:0]                    confidence_value
);
    import ddmcw_pkg::*;

    // configuration
    logic [30:0] bound_upper_reg;
    logic [30:0] start_evidence_reg;
    logic [31:0] drift_step_reg;
    logic [31:0] post_drift_step_reg;
    logic [30:0] noise_gain_reg;
    logic [30:0] confidence_width_reg;
    logic [30:0] urgency_step_reg;
    logic [15:0] nondecision_steps_reg;

    // multiply stage
    logic                  noise_valid_reg;
    logic [NOISE_W-1:0]    noise_reg;
    logic signed [47:0]    product;
    logic signed [47:0]    product_rounded;

    // walk state
    logic        phase_reg;
    logic [31:0] evidence_reg;
    logic [31:0] collapse_reg;
    logic [31:0] step_count_reg;
    logic [31:0] decision_count_reg;
    logic        hit_upper_reg;
    logic        was_correct_reg;
    logic [31:0] trial_counter_reg;

    // result register
    logic        result_valid_reg;
    logic [31:0] trial_index_reg;
    logic [31:0] decision_rt_reg;
    logic        response_upper_reg;
    logic        correct_reg;
    logic [31:0] final_evidence_reg;
    logic [31:0] full_rt_reg;
    logic [31:0] confidence_rt_reg;
    logic [31:0] confidence_value_reg;

    // walk update
    logic               advance;
    logic [31:0]        step_inc;
    logic [SUM_W-1:0]   noise_ext;
    logic [31:0]        walk;
    logic signed [32:0] walk_ext;
    logic signed [32:0] bound_ext;
    logic               phase_next;
    logic [31:0]        evidence_next;
    logic [31:0]        collapse_next;
    logic [31:0]        decision_next;
    logic               hit_next;
    logic               correct_next;
    logic               decided_done;
    logic [32:0]        rel;
    logic [33:0]        rel_oriented;
    logic signed [35:0] rel2;
    logic signed [35:0] limit;
    logic signed [35:0] neg_limit;
    logic               crossed;
    logic               emit;

    assign advance      = noise_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = noise_valid_reg && !advance;

    assign product         = 48'($signed({1'b0, noise_gain_reg})) * 48'(noise_sample);
    assign product_rounded = product + 48'sd2048;

    always_comb
    begin
        step_inc      = sat_add_u32(step_count_reg, 32'd1);
        noise_ext     = {{(SUM_W-NOISE_W){noise_reg[NOISE_W-1]}}, noise_reg};
        phase_next    = phase_reg;
        collapse_next = collapse_reg;
        decision_next = decision_count_reg;
        hit_next      = hit_upper_reg;
        correct_next  = was_correct_reg;
        decided_done  = 1'b0;
        bound_ext     = $signed({2'b00, bound_upper_reg});
        if (!phase_reg)
        begin
            walk = sat32({{(SUM_W-32){evidence_reg[31]}}, evidence_reg}
                       + {{(SUM_W-32){drift_step_reg[31]}}, drift_step_reg}
                       + noise_ext);
        end
        else
        begin
            walk = sat32({{(SUM_W-32){evidence_reg[31]}}, evidence_reg}
                       + {{(SUM_W-32){post_drift_step_reg[31]}}, post_drift_step_reg}
                       + noise_ext);
        end
        walk_ext      = $signed({walk[31], walk});
        evidence_next = walk;
        if (!phase_reg)
        begin
            // upper bound is tested first so a zero bound resolves upward
            if (walk_ext >= bound_ext)
            begin
                hit_next      = 1'b1;
                correct_next  = !drift_step_reg[31];
                evidence_next = {1'b0, bound_upper_reg};
                phase_next    = 1'b1;
                decision_next = step_inc;
                decided_done  = (confidence_width_reg == '0);
            end
            else if (walk_ext <= 33'sd0)
            begin
                hit_next      = 1'b0;
                correct_next  = drift_step_reg[31];
                evidence_next = '0;
                phase_next    = 1'b1;
                decision_next = step_inc;
                decided_done  = (confidence_width_reg == '0);
            end
        end
        else
        begin
            collapse_next = sat_add_u32(collapse_reg, {1'b0, urgency_step_reg});
        end

        // evidence relative to the hit bound
        rel = {evidence_next[31], evidence_next}
            - (hit_next ? {2'b00, bound_upper_reg} : 33'd0);
        rel_oriented = hit_next ? {rel[32], rel} : (34'd0 - {rel[32], rel});
        rel2      = $signed({{2{rel[32]}}, rel, 1'b0});
        limit     = $signed({5'b0, confidence_width_reg})
                  - $signed({3'b0, collapse_next, 1'b0});
        neg_limit = 36'sd0 - limit;
        crossed   = (rel2 >= limit) || (rel2 <= neg_limit);
        emit      = phase_reg ? crossed : decided_done;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_upper_reg       <= RESET_BOUND_UPPER;
            start_evidence_reg    <= RESET_START_EVIDENCE;
            drift_step_reg        <= '0;
            post_drift_step_reg   <= '0;
            noise_gain_reg        <= RESET_NOISE_GAIN;
            confidence_width_reg  <= RESET_CONF_WIDTH;
            urgency_step_reg      <= '0;
            nondecision_steps_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BOUND_UPPER:       bound_upper_reg       <= cfg_data[30:0];
                REG_START_EVIDENCE:    start_evidence_reg    <= cfg_data[30:0];
                REG_DRIFT_STEP:        drift_step_reg        <= cfg_data;
                REG_POST_DRIFT_STEP:   post_drift_step_reg   <= cfg_data;
                REG_NOISE_GAIN:        noise_gain_reg        <= cfg_data[30:0];
                REG_CONFIDENCE_WIDTH:  confidence_width_reg  <= cfg_data[30:0];
                REG_URGENCY_STEP:      urgency_step_reg      <= cfg_data[30:0];
                REG_NONDECISION_STEPS: nondecision_steps_reg <= cfg_data[15:0];
            endcase
        end
    end

    // control: stage valids and walk state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_valid_reg    <= 1'b0;
            result_valid_reg   <= 1'b0;
            phase_reg          <= 1'b0;
            evidence_reg       <= {1'b0, RESET_START_EVIDENCE};
            collapse_reg       <= '0;
            step_count_reg     <= '0;
            decision_count_reg <= '0;
            hit_upper_reg      <= 1'b0;
            was_correct_reg    <= 1'b0;
            trial_counter_reg  <= '0;
        end
        else
        begin
            if (!noise_valid_reg || advance)
            begin
                noise_valid_reg <= sample_valid;
            end
            if (!result_valid_reg || !result_stall)
            begin
                result_valid_reg <= advance && emit;
            end
            if (advance)
            begin
                hit_upper_reg   <= hit_next;
                was_correct_reg <= correct_next;
                if (emit)
                begin
                    // next trial starts fresh
                    phase_reg          <= 1'b0;
                    evidence_reg       <= {1'b0, start_evidence_reg};
                    collapse_reg       <= '0;
                    step_count_reg     <= '0;
                    decision_count_reg <= '0;
                    trial_counter_reg  <= sat_add_u32(trial_counter_reg, 32'd1);
                end
                else
                begin
                    phase_reg          <= phase_next;
                    evidence_reg       <= evidence_next;
                    collapse_reg       <= collapse_next;
                    step_count_reg     <= step_inc;
                    decision_count_reg <= decision_next;
                end
            end
            else if (cfg_write && (cfg_index == REG_START_EVIDENCE) && !phase_reg
                     && (step_count_reg == '0))
            begin
                // trial not started yet: take the new start point now
                evidence_reg <= {1'b0, cfg_data[30:0]};
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!noise_valid_reg || advance)
        begin
            noise_reg <= product_rounded[47:12];
        end
        if (advance && emit)
        begin
            trial_index_reg      <= trial_counter_reg;
            decision_rt_reg      <= sat_add_u32(decision_next, {16'd0, nondecision_steps_reg});
            response_upper_reg   <= hit_next;
            correct_reg          <= correct_next;
            final_evidence_reg   <= evidence_next;
            full_rt_reg          <= sat_add_u32(step_inc, {16'd0, nondecision_steps_reg});
            confidence_rt_reg    <= step_inc - decision_next;
            confidence_value_reg <= sat32({{(SUM_W-34){rel_oriented[33]}}, rel_oriented});
        end
    end

    assign result_valid     = result_valid_reg;
    assign trial_index      = trial_index_reg;
    assign decision_rt      = decision_rt_reg;
    assign response_upper   = response_upper_reg;
    assign correct          = correct_reg;
    assign final_evidence   = $signed(final_evidence_reg);
    assign full_rt          = full_rt_reg;
    assign confidence_rt    = confidence_rt_reg;
    assign confidence_value = $signed(confidence_value_reg);

    // checks
    a_collapse_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_reg |-> (collapse_reg == '0))
        else $error("collapse accumulated during decision phase");

    a_decision_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !phase_reg |-> (decision_count_reg == '0))
        else $error("decision count set before a bound was hit");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        decision_count_reg <= step_count_reg)
        else $error("decision count exceeds step count");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (noise_valid_reg && result_valid_reg && result_stall))
        else $error("sample request stalled without a blocked result");

    a_emit_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && emit) |=> (result_valid && !phase_reg && (step_count_reg == '0)))
        else $error("finished trial did not produce a result and restart");

endmodule

// ===== bench/tb_ddm_confidence_walk_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ddm_confidence_walk_unit
// Drives noise samples into the confidence walk unit, runs its own copy of
// the walk at the same widths, and compares every trial summary field by
// field. Registers change only between phases, once the unit has drained.
// ----------------------------------------------------------------------------
module tb_ddm_confidence_walk_unit;

    import ddmcw_pkg::*;

    localparam int NUM_REGS      = 8;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STUCK_LIMIT   = 1000;
    localparam int RANDOM_PHASES = 17;
    localparam int PHASE_SAMPLES = 100;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;
    localparam longint U32_MAX = 64'sd4294967295;

    typedef enum logic {WALK_DECIDE, WALK_CONFIRM} walk_phase_t;

    typedef struct packed {
        logic [31:0] trial_index;
        logic [31:0] decision_rt;
        logic        response_upper;
        logic        correct;
        logic [31:0] final_evidence;
        logic [31:0] full_rt;
        logic [31:0] confidence_rt;
        logic [31:0] confidence_value;
    } trial_summary_t;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_write    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [CFG_DATA_W-1:0]  cfg_data     = '0;
    logic                   sample_valid = 1'b0;
    logic                   sample_stall;
    logic signed [15:0]     noise_sample = '0;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    logic [31:0]            trial_index;
    logic [31:0]            decision_rt;
    logic                   response_upper;
    logic                   correct;
    logic signed [31:0]     final_evidence;
    logic [31:0]            full_rt;
    logic [31:0]            confidence_rt;
    logic signed [31:0]     confidence_value;

    // walk predictor: register copies and trial state
    logic [30:0]  bound_reg;
    logic [30:0]  start_reg;
    logic [31:0]  drift_reg;
    logic [31:0]  post_drift_reg;
    logic [30:0]  gain_reg;
    logic [30:0]  width_reg;
    logic [30:0]  urgency_reg;
    logic [15:0]  nondecision_reg;
    walk_phase_t  walk_phase;
    logic [31:0]  evidence;
    logic [31:0]  collapse;
    logic [31:0]  step_total;
    logic [31:0]  decide_steps;
    logic [31:0]  trial_count;
    logic         hit_upper;
    logic         decided_right;

    logic [15:0]    samples_pending[$];
    trial_summary_t summaries_due[$];
    logic [31:0]    reg_plan[NUM_REGS];

    int unsigned gap_max     = 7;
    int unsigned stall_max   = 7;
    int unsigned send_wait   = 0;
    int unsigned hold_left   = 0;
    int          quiet_cycles = 0;
    int          error_count  = 0;

    ddm_confidence_walk_unit DUT
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .sample_valid     (sample_valid),
        .sample_stall     (sample_stall),
        .noise_sample     (noise_sample),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .trial_index      (trial_index),
        .decision_rt      (decision_rt),
        .response_upper   (response_upper),
        .correct          (correct),
        .final_evidence   (final_evidence),
        .full_rt          (full_rt),
        .confidence_rt    (confidence_rt),
        .confidence_value (confidence_value)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [31:0] clamp_s32(input longint v);
        logic [31:0] r;
        if (v > S32_MAX)
            r = 32'h7FFF_FFFF;
        else if (v < S32_MIN)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] clip_sum_u32(input logic [31:0] a, input logic [31:0] b);
        longint s;
        s = longint'(a);
        s = s + longint'(b);
        return (s > U32_MAX) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void start_trial();
        walk_phase   = WALK_DECIDE;
        evidence     = {1'b0, start_reg};
        collapse     = '0;
        step_total   = '0;
        decide_steps = '0;
    endfunction

    function automatic void walk_reset();
        bound_reg       = RESET_BOUND_UPPER;
        start_reg       = RESET_START_EVIDENCE;
        drift_reg       = '0;
        post_drift_reg  = '0;
        gain_reg        = RESET_NOISE_GAIN;
        width_reg       = RESET_CONF_WIDTH;
        urgency_reg     = '0;
        nondecision_reg = '0;
        hit_upper       = 1'b0;
        decided_right   = 1'b0;
        trial_count     = '0;
        start_trial();
    endfunction

    function automatic void walk_reg_write(input cfg_index_t idx, input logic [31:0] val);
        case (idx)
            REG_BOUND_UPPER:       bound_reg = val[30:0];
            REG_START_EVIDENCE:
            begin
                start_reg = val[30:0];
                // a trial that has not stepped yet picks up the new start
                if (walk_phase == WALK_DECIDE && step_total == 0)
                    evidence = {1'b0, val[30:0]};
            end
            REG_DRIFT_STEP:        drift_reg = val;
            REG_POST_DRIFT_STEP:   post_drift_reg = val;
            REG_NOISE_GAIN:        gain_reg = val[30:0];
            REG_CONFIDENCE_WIDTH:  width_reg = val[30:0];
            REG_URGENCY_STEP:      urgency_reg = val[30:0];
            REG_NONDECISION_STEPS: nondecision_reg = val[15:0];
            default:               ;
        endcase
    endfunction

    // one walk step; returns 1 when the step finishes a trial
    function automatic bit walk_step(input logic [15:0] smp, output trial_summary_t res);
        longint g;
        longint prod;
        longint noise;
        longint acc;
        longint center;
        longint rel;
        longint lim;
        bit     decided;
        bit     done;
        decided = 1'b0;
        done    = 1'b0;
        res     = '0;
        g       = longint'(gain_reg);
        prod    = longint'($signed(smp));
        prod    = prod * g + 2048;
        noise   = prod >>> 12;
        step_total = clip_sum_u32(step_total, 32'd1);
        if (walk_phase == WALK_DECIDE)
        begin
            acc      = longint'($signed(evidence));
            acc      = acc + longint'($signed(drift_reg)) + noise;
            evidence = clamp_s32(acc);
            acc      = longint'($signed(evidence));
            g        = longint'(bound_reg);
            // upper bound wins when both could match
            if (acc >= g)
            begin
                hit_upper     = 1'b1;
                decided_right = ~drift_reg[31];
                evidence      = {1'b0, bound_reg};
                decided       = 1'b1;
            end
            else if (acc <= 0)
            begin
                hit_upper     = 1'b0;
                decided_right = drift_reg[31];
                evidence      = '0;
                decided       = 1'b1;
            end
            if (decided)
            begin
                decide_steps = step_total;
                walk_phase   = WALK_CONFIRM;
                done         = (width_reg == 0);
            end
        end
        else
        begin
            collapse = clip_sum_u32(collapse, {1'b0, urgency_reg});
            acc      = longint'($signed(evidence));
            acc      = acc + longint'($signed(post_drift_reg)) + noise;
            evidence = clamp_s32(acc);
            acc      = longint'($signed(evidence));
            center   = hit_upper ? longint'(bound_reg) : 0;
            rel      = acc - center;
            g        = longint'(collapse);
            lim      = longint'(width_reg) - 2 * g;
            done     = (2 * rel >= lim) || (2 * rel <= -lim);
        end
        if (done)
        begin
            acc    = longint'($signed(evidence));
            center = hit_upper ? longint'(bound_reg) : 0;
            rel    = acc - center;
            res.trial_index      = trial_count;
            res.decision_rt      = clip_sum_u32(decide_steps, {16'd0, nondecision_reg});
            res.response_upper   = hit_upper;
            res.correct          = decided_right;
            res.final_evidence   = evidence;
            res.full_rt          = clip_sum_u32(step_total, {16'd0, nondecision_reg});
            res.confidence_rt    = step_total - decide_steps;
            res.confidence_value = clamp_s32(hit_upper ? rel : -rel);
            trial_count = clip_sum_u32(trial_count, 32'd1);
            start_trial();
        end
        return done;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t mismatch %s: expected %h actual %h", $time, what, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [15:0] draw_noise();
        logic [15:0] v;
        case ($urandom_range(0, 19))
            0:       v = 16'($urandom());
            1:       v = 16'h7FFF;
            2:       v = 16'h8000;
            default: v = 16'($urandom_range(0, 16383) - 8192);
        endcase
        return v;
    endfunction

    // sample driver
    always @(posedge clk or negedge rst_n)
    begin : sample_driver
        trial_summary_t due;
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            noise_sample <= '0;
            send_wait    <= 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                if (walk_step(noise_sample, due))
                    summaries_due.push_back(due);
            end
            if (!(sample_valid && sample_stall))
            begin
                if (send_wait != 0)
                begin
                    send_wait    <= send_wait - 1;
                    sample_valid <= 1'b0;
                end
                else if (samples_pending.size() != 0)
                begin
                    noise_sample <= samples_pending.pop_front();
                    sample_valid <= 1'b1;
                    send_wait    <= $urandom_range(0, gap_max);
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        trial_summary_t want;
        int unsigned    left;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            hold_left    <= 0;
        end
        else
        begin
            left = hold_left;
            if (result_valid && !result_stall)
            begin
                if (summaries_due.size() == 0)
                begin
                    $display("%0t unexpected trial summary: expected none actual trial %h",
                             $time, trial_index);
                    error_count++;
                end
                else
                begin
                    want = summaries_due.pop_front();
                    check_field("trial_index", want.trial_index, trial_index);
                    check_field("decision_rt", want.decision_rt, decision_rt);
                    check_field("response_upper", {31'd0, want.response_upper},
                                {31'd0, response_upper});
                    check_field("correct", {31'd0, want.correct}, {31'd0, correct});
                    check_field("final_evidence", want.final_evidence, final_evidence);
                    check_field("full_rt", want.full_rt, full_rt);
                    check_field("confidence_rt", want.confidence_rt, confidence_rt);
                    check_field("confidence_value", want.confidence_value, confidence_value);
                end
                left = $urandom_range(0, stall_max);
            end
            else if (left != 0)
            begin
                left = left - 1;
            end
            hold_left    <= left;
            result_stall <= (left != 0);
        end
    end

    // cycles without any request or register write
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < STUCK_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    task automatic settle();
        while (samples_pending.size() != 0 || sample_valid || summaries_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [31:0] bnd, input logic [31:0] st,
                                input logic [31:0] dr, input logic [31:0] pdr,
                                input logic [31:0] gn, input logic [31:0] wd,
                                input logic [31:0] ur, input logic [31:0] nd);
        cfg_index_t idx;
        reg_plan[REG_BOUND_UPPER]       = bnd;
        reg_plan[REG_START_EVIDENCE]    = st;
        reg_plan[REG_DRIFT_STEP]        = dr;
        reg_plan[REG_POST_DRIFT_STEP]   = pdr;
        reg_plan[REG_NOISE_GAIN]        = gn;
        reg_plan[REG_CONFIDENCE_WIDTH]  = wd;
        reg_plan[REG_URGENCY_STEP]      = ur;
        reg_plan[REG_NONDECISION_STEPS] = nd;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            idx = cfg_index_t'(i);
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= reg_plan[i];
            walk_reg_write(idx, reg_plan[i]);
            @(posedge clk);
        end
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        logic [31:0] top;
        logic [31:0] bnd;
        logic [31:0] st;
        logic [31:0] gn;
        logic [31:0] dr;
        logic [31:0] pdr;
        logic [31:0] wd;
        logic [31:0] ur;
        walk_reset();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // rounding ties with unit gain, full-scale samples
        program_regs(32'd65536, 32'd32768, 32'd0, 32'd0, 32'd1, 32'd65536, 32'd0, 32'd0);
        samples_pending.push_back(16'd2048);
        samples_pending.push_back(-16'sd2048);
        samples_pending.push_back(16'd6144);
        samples_pending.push_back(-16'sd6144);
        samples_pending.push_back(16'h7FFF);
        samples_pending.push_back(16'h8000);
        samples_pending.push_back(16'd0);
        samples_pending.push_back(16'd1);
        samples_pending.push_back(16'hFFFF);
        settle();

        // zero width ends on the deciding step; zero bound with zero evidence is upper
        program_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd100);
        samples_pending.push_back(16'd0);
        samples_pending.push_back(16'h7FFF);
        samples_pending.push_back(16'h8000);
        samples_pending.push_back(16'd1);
        samples_pending.push_back(16'hFFFF);
        settle();

        // saturation at every stage, masked upper bits
        program_regs(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
        samples_pending.push_back(16'h7FFF);
        samples_pending.push_back(16'h7FFF);
        samples_pending.push_back(16'h8000);
        settle();

        // collapse past half the width ends the confidence phase at once
        program_regs(32'h7FFF_FFFF, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
        samples_pending.push_back(16'h8000);
        samples_pending.push_back(16'h7FFF);
        samples_pending.push_back(16'd0);
        samples_pending.push_back(16'h8000);
        settle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            top = 32'd1 << $urandom_range(12, 30);
            bnd = $urandom_range(4096, top);
            st  = $urandom_range(0, bnd);
            gn  = bnd / $urandom_range(2, 8) + 1;
            dr  = $urandom_range(0, gn) - (gn >> 1);
            pdr = $urandom_range(0, gn) - (gn >> 1);
            wd  = ($urandom_range(0, 5) == 0) ? 32'd0 : ($urandom_range(1, gn) << $urandom_range(0, 2));
            ur  = ($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(0, gn >> 2);
            // junk above the register width must be dropped
            bnd = bnd | ($urandom_range(0, 1) << 31);
            st  = st | ($urandom_range(0, 1) << 31);
            gn  = gn | ($urandom_range(0, 1) << 31);
            wd  = wd | ($urandom_range(0, 1) << 31);
            ur  = ur | ($urandom_range(0, 1) << 31);
            case (p % 4)
                1:       begin gap_max = 0; stall_max = 7; end
                3:       begin gap_max = 0; stall_max = 0; end
                default: begin gap_max = 7; stall_max = 7; end
            endcase
            program_regs(bnd, st, dr, pdr, gn, wd, ur, $urandom());
            for (int k = 0; k < PHASE_SAMPLES; k++)
                samples_pending.push_back(draw_noise());
            settle();
        end

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
src/ddmcw_pkg.sv
src/ddm_confidence_walk_unit.sv
bench/tb_ddm_confidence_walk_unit.sv
